### design/tee_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text escape / entity decoder package
// Character codes, escape strings, the command word passed from the front
// end to the back end, and the escape and entity lookup functions.
// ----------------------------------------------------------------------------
package tee_pkg;

  // Results of one item before the tail spills into the next item
  localparam logic [5:0] MAX_RES = 6'd18;

  // Character codes
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SP     = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_BSL    = 8'h5C;
  localparam logic [7:0] CH_CARET  = 8'h5E;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_TILDE  = 8'h7E;

  // Entity names, first letter in the top byte
  localparam logic [15:0] NAME_LT   = "lt";
  localparam logic [15:0] NAME_GT   = "gt";
  localparam logic [23:0] NAME_AMP  = "amp";
  localparam logic [31:0] NAME_QUOT = "quot";

  // Multi-byte escape sequences, first byte in the top byte
  localparam logic [31:0] ESC_CARET     = "\\^{}";
  localparam logic [95:0] ESC_BACKSLASH = "$\\backslash$";
  localparam logic [95:0] ESC_TILDE     = "{\\char'0176}";
  localparam logic [87:0] ESC_QUOTE     = "{\\char'042}";
  localparam logic [15:0] ESC_DASH      = "\"-";

  // Bytes off..stop-1 of the escape sequence of one character
  typedef struct packed {
    logic [7:0] ch;
    logic       raw;
    logic [3:0] off;
    logic [3:0] stop;
  } esc_seg_t;

  // Up to five literal bytes, b[0] first
  typedef struct packed {
    logic [4:0][7:0] b;
    logic [2:0]      n;
  } lit_seg_t;

  // One item's output, sent in the order
  // esc[0], esc[1], lit[0], lit[1], esc[2], esc[3], lit[2], lit[3]
  typedef struct packed {
    esc_seg_t [3:0] esc;
    lit_seg_t [3:0] lit;
  } cmd_t;

  function automatic logic is_letter(input logic [7:0] ch);
    return ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
  endfunction

  function automatic logic is_ws(input logic [7:0] ch);
    return (ch == CH_SP) || (ch == CH_TAB) || (ch == CH_NL) ||
           (ch == CH_VT) || (ch == CH_FF) || (ch == CH_CR);
  endfunction

  // Length of the escape sequence of one character
  function automatic logic [3:0] esc_len(input logic [7:0] ch, input logic raw);
    logic [3:0] len;
    len = 4'd1;
    if (!raw) begin
      case (ch)
        CH_CARET:  len = 4'd4;
        CH_BSL:    len = 4'd12;
        CH_TILDE:  len = 4'd12;
        CH_DQUOTE: len = 4'd11;
        CH_DASH:   len = 4'd2;
        CH_AMP, CH_DOLLAR, CH_LBRACE, CH_RBRACE, CH_PCT, CH_HASH, CH_USCORE: len = 4'd2;
        default:   len = 4'd1;
      endcase
    end
    return len;
  endfunction

  // Byte at position pos of the escape sequence of one character
  function automatic logic [7:0] esc_byte(input logic [7:0] ch, input logic raw,
                                          input logic [3:0] pos);
    logic [95:0] s;
    logic [3:0]  sh;
    s = {ch, 88'h0};
    if (!raw) begin
      case (ch)
        CH_CARET:  s = {ESC_CARET, 64'h0};
        CH_BSL:    s = ESC_BACKSLASH;
        CH_TILDE:  s = ESC_TILDE;
        CH_DQUOTE: s = {ESC_QUOTE, 8'h0};
        CH_DASH:   s = {ESC_DASH, 80'h0};
        CH_AMP, CH_DOLLAR, CH_LBRACE, CH_RBRACE, CH_PCT, CH_HASH, CH_USCORE:
          s = {CH_BSL, ch, 80'h0};
        default:   s = {ch, 88'h0};
      endcase
    end
    sh = 4'd11 - pos;
    return s[{sh, 3'b000} +: 8];
  endfunction

  // Decoded character of a held entity name, zero when unknown
  function automatic logic [7:0] lookup(input logic [3:0][7:0] ltr, input logic [2:0] len);
    logic [7:0] rep;
    rep = 8'h00;
    if ((len == 3'd2) && ({ltr[0], ltr[1]} == NAME_LT)) begin
      rep = CH_LT;
    end else if ((len == 3'd2) && ({ltr[0], ltr[1]} == NAME_GT)) begin
      rep = CH_GT;
    end else if ((len == 3'd3) && ({ltr[0], ltr[1], ltr[2]} == NAME_AMP)) begin
      rep = CH_AMP;
    end else if ((len == 3'd4) && ({ltr[0], ltr[1], ltr[2], ltr[3]} == NAME_QUOT)) begin
      rep = CH_DQUOTE;
    end
    return rep;
  endfunction

endpackage

### design/tee_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Front end: item classifier
// Tracks entity and whitespace state, and turns each accepted item into one
// command word that lists the output segments of that item in order.
// ----------------------------------------------------------------------------
module tee_front import tee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       raw_mode,
  input  logic       accept,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  output cmd_t       cmd
);

  // Entity and whitespace state
  logic            ent_open_r, ent_open_nxt;
  logic [2:0]      ent_len_r, ent_len_nxt;
  logic [3:0][7:0] ltr_r, ltr_nxt;
  logic            run_open_r, run_open_nxt;
  logic            run_nl_r, run_nl_nxt;

  // Tail of an item that went past the result limit
  logic            carry_vld_r, carry_vld_nxt;
  logic [7:0]      carry_ch_r, carry_ch_nxt;
  logic            carry_raw_r, carry_raw_nxt;
  logic [3:0]      carry_off_r, carry_off_nxt;

  logic            letter;
  logic            ws;
  logic            plain;
  logic            reopened;
  logic [7:0]      rep;
  logic [3:0]      len_p, len_e1;
  logic [4:0]      lead_len;
  logic [5:0]      total;
  logic [5:0]      room;

  function automatic esc_seg_t mk_esc(input logic [7:0] ch, input logic raw);
    esc_seg_t s;
    s.ch   = ch;
    s.raw  = raw;
    s.off  = 4'd0;
    s.stop = esc_len(ch, raw);
    return s;
  endfunction

  // Classify the item and build its command word
  always_comb begin
    cmd           = '0;
    ent_open_nxt  = ent_open_r;
    ent_len_nxt   = ent_len_r;
    ltr_nxt       = ltr_r;
    run_open_nxt  = run_open_r;
    run_nl_nxt    = run_nl_r;
    carry_vld_nxt = carry_vld_r;
    carry_ch_nxt  = carry_ch_r;
    carry_raw_nxt = carry_raw_r;
    carry_off_nxt = carry_off_r;
    plain         = 1'b0;
    reopened      = 1'b0;
    letter        = is_letter(text_byte);
    ws            = is_ws(text_byte) && !raw_mode;

    // Spilled tail of the previous item goes out first
    if (carry_vld_r) begin
      cmd.esc[0].ch   = carry_ch_r;
      cmd.esc[0].raw  = carry_raw_r;
      cmd.esc[0].off  = carry_off_r;
      cmd.esc[0].stop = esc_len(carry_ch_r, carry_raw_r);
      carry_vld_nxt   = 1'b0;
    end

    // Store a letter of an open name while it still fits
    if (ent_open_r && letter && (ent_len_r < 3'd4)) begin
      ltr_nxt[ent_len_r[1:0]] = text_byte;
      ent_len_nxt             = ent_len_r + 3'd1;
    end
    rep = lookup(ltr_nxt, ent_len_nxt);

    // Open entity: extend, decode or give up on it
    if (ent_open_r) begin
      if (letter) begin
        if (ent_len_r == 3'd4) begin
          // name too long: flush it with the new letter
          cmd.esc[1]   = mk_esc(CH_AMP, raw_mode);
          cmd.lit[0].b = {text_byte, ltr_r[3], ltr_r[2], ltr_r[1], ltr_r[0]};
          cmd.lit[0].n = 3'd5;
          ent_open_nxt = 1'b0;
          ent_len_nxt  = 3'd0;
        end
      end else if ((text_byte == CH_SEMI) && (rep != 8'h00)) begin
        // known name, semicolon consumed
        cmd.esc[1]   = mk_esc(rep, raw_mode);
        ent_open_nxt = 1'b0;
        ent_len_nxt  = 3'd0;
      end else begin
        if (rep != 8'h00) begin
          cmd.esc[1] = mk_esc(rep, raw_mode);
        end else begin
          cmd.esc[1]   = mk_esc(CH_AMP, raw_mode);
          cmd.lit[0].b = {8'h00, ltr_r};
          cmd.lit[0].n = ent_len_r;
        end
        ent_open_nxt = 1'b0;
        ent_len_nxt  = 3'd0;
        plain        = 1'b1;
      end
    end else begin
      plain = 1'b1;
    end

    // Plain byte: whitespace run, entity start or escaped character
    if (plain) begin
      if (!ws && run_open_nxt) begin
        cmd.lit[1].b[0] = run_nl_nxt ? CH_NL : CH_SP;
        cmd.lit[1].n    = 3'd1;
        run_open_nxt    = 1'b0;
        run_nl_nxt      = 1'b0;
      end
      if (ws) begin
        run_open_nxt = 1'b1;
        if (text_byte == CH_NL) begin
          run_nl_nxt = 1'b1;
        end
      end else if (text_byte == CH_AMP) begin
        ent_open_nxt = 1'b1;
        ent_len_nxt  = 3'd0;
        reopened     = 1'b1;
      end else begin
        cmd.esc[2] = mk_esc(text_byte, raw_mode);
      end
    end

    // End of text: resolve the open name, flush the run, clear
    if (end_of_text) begin
      if (ent_open_nxt) begin
        if (!reopened && (rep != 8'h00)) begin
          cmd.esc[3] = mk_esc(rep, raw_mode);
        end else begin
          cmd.esc[3] = mk_esc(CH_AMP, raw_mode);
          if (!reopened) begin
            cmd.lit[2].b = {8'h00, ltr_nxt};
            cmd.lit[2].n = ent_len_nxt;
          end
        end
      end
      if (run_open_nxt) begin
        cmd.lit[3].b[0] = run_nl_nxt ? CH_NL : CH_SP;
        cmd.lit[3].n    = 3'd1;
      end
      ent_open_nxt = 1'b0;
      ent_len_nxt  = 3'd0;
      run_open_nxt = 1'b0;
      run_nl_nxt   = 1'b0;
    end

    // Cut the escaped character at the result limit and hold the rest.
    // Only a decoded quote followed by a long escape gets there, and then
    // nothing follows the character in the same item.
    len_p    = cmd.esc[0].stop - cmd.esc[0].off;
    len_e1   = cmd.esc[1].stop - cmd.esc[1].off;
    lead_len = {1'b0, len_p} + {1'b0, len_e1} + {2'b00, cmd.lit[0].n} +
               {2'b00, cmd.lit[1].n};
    total    = {1'b0, lead_len} + {2'b00, cmd.esc[2].stop};
    room     = MAX_RES - {1'b0, lead_len};
    if ((cmd.esc[2].stop != 4'd0) && (total > MAX_RES)) begin
      cmd.esc[2].stop = room[3:0];
      carry_vld_nxt   = 1'b1;
      carry_ch_nxt    = text_byte;
      carry_raw_nxt   = raw_mode;
      carry_off_nxt   = room[3:0];
    end
  end

  // Advance control state on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_open_r  <= 1'b0;
      ent_len_r   <= 3'd0;
      run_open_r  <= 1'b0;
      run_nl_r    <= 1'b0;
      carry_vld_r <= 1'b0;
    end else if (accept) begin
      ent_open_r  <= ent_open_nxt;
      ent_len_r   <= ent_len_nxt;
      run_open_r  <= run_open_nxt;
      run_nl_r    <= run_nl_nxt;
      carry_vld_r <= carry_vld_nxt;
    end
  end

  // Hold letters and spilled tail
  always_ff @(posedge clk) begin
    if (accept) begin
      ltr_r       <= ltr_nxt;
      carry_ch_r  <= carry_ch_nxt;
      carry_raw_r <= carry_raw_nxt;
      carry_off_r <= carry_off_nxt;
    end
  end

endmodule

### design/tee_cmd_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short register queue of command words between front end and back end;
// the oldest word is shown at the head.
// ----------------------------------------------------------------------------
module tee_cmd_fifo import tee_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  cmd_t wr_data,
  input  logic rd_en,
  output cmd_t rd_data,
  output logic full,
  output logic empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    case ({wr_en, rd_en})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### design/tee_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Back end: byte expander
// Walks the segments of the head command word one byte per clock while the
// result register is empty or being popped, loading the bytes into it and
// marking the last byte of each word.
module tee_back import tee_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cmd_t       head,
  input  logic       head_vld,
  output logic       head_pop,
  input  logic       out_pop,
  output logic       out_vld,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic [7:0] done_r, done_nxt;
  logic [3:0] idx_r, idx_nxt;
  logic       out_vld_r;
  logic [7:0] out_byte_r;
  logic       out_last_r;

  logic [7:0] filled;
  logic [7:0] pend;
  logic [7:0] rest;
  logic [2:0] sel;
  esc_seg_t   es;
  lit_seg_t   ls;
  logic [3:0] pos;
  logic [7:0] byte_val;
  logic       seg_last;
  logic       out_rdy;
  logic       emit;

  // Find the next segment that still has bytes
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (k[1] == 1'b0) begin
        filled[k] = head.esc[{k[2], k[0]}].off != head.esc[{k[2], k[0]}].stop;
      end else begin
        filled[k] = head.lit[{k[2], k[0]}].n != 3'd0;
      end
    end
    pend = head_vld ? (filled & ~done_r) : 8'h00;
    sel  = 3'd0;
    for (int k = 7; k >= 0; k--) begin
      if (pend[k]) begin
        sel = 3'(k);
      end
    end
    rest = pend & ~(8'h01 << sel);
  end

  // Pick the byte of the current segment
  always_comb begin
    es  = head.esc[{sel[2], sel[0]}];
    ls  = head.lit[{sel[2], sel[0]}];
    pos = es.off + idx_r;
    if (sel[1] == 1'b0) begin
      byte_val = esc_byte(es.ch, es.raw, pos);
      seg_last = ({1'b0, pos} + 5'd1) == {1'b0, es.stop};
    end else begin
      byte_val = ls.b[idx_r[2:0]];
      seg_last = ({1'b0, idx_r[2:0]} + 4'd1) == {1'b0, ls.n};
    end
  end

  assign out_rdy  = !out_vld_r || out_pop;
  assign emit     = (pend != 8'h00) && out_rdy;
  assign head_pop = head_vld && ((pend == 8'h00) || (emit && seg_last && (rest == 8'h00)));

  // Advance through the segments; drop the word after its last byte, or at once when it has none
  always_comb begin
    done_nxt = done_r;
    idx_nxt  = idx_r;
    if (head_pop) begin
      done_nxt = 8'h00;
      idx_nxt  = 4'd0;
    end else if (emit) begin
      if (seg_last) begin
        done_nxt = done_r | (8'h01 << sel);
        idx_nxt  = 4'd0;
      end else begin
        idx_nxt = idx_r + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r    <= 8'h00;
      idx_r     <= 4'd0;
      out_vld_r <= 1'b0;
    end else begin
      done_r <= done_nxt;
      idx_r  <= idx_nxt;
      if (emit) begin
        out_vld_r <= 1'b1;
      end else if (out_pop) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Hold the result word until it is taken
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r <= byte_val;
      out_last_r <= seg_last && (rest == 8'h00);
    end
  end

  assign out_vld  = out_vld_r;
  assign out_byte = out_byte_r;
  assign out_last = out_last_r;

endmodule

### design/text_escape_entity_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text escape and entity decoder, top level
// Decodes &lt; &gt; &amp; &quot;, collapses whitespace runs and escapes text bytes for a typesetter.
// ----------------------------------------------------------------------------
// Each pushed byte is classified in the cycle it is accepted and turned into
// a command word in a QUEUE_DEPTH-entry queue; the back end then emits the
// result bytes of the oldest word through a single result register at one
// byte per clock while that register is empty or being popped, so a stream
// of plain text runs at one word per clock. A word with a multi-byte escape
// holds the back end until its last byte is sent, and a word that gives no
// output (whitespace inside a run, letters of an entity name) is dropped
// from the queue. Input is refused (full) only while the queue holds
// QUEUE_DEPTH words. out_last_of_run marks the final byte of each input
// word; when an item would give more than 18 bytes the rest is sent at the
// start of the next word's output. There is no clearing pass after reset.
// raw_mode is written through the cfg_ channel, which is always ready.
module text_escape_entity_decoder import tee_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_text_byte,
  input  logic       in_end_of_text,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       out_last_of_run,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       cfg_raw_mode
);

  logic raw_mode_r;
  logic in_acc;
  cmd_t cmd;
  cmd_t head;
  logic q_empty;
  logic head_pop;
  logic out_vld;

  assign cfg_ready = 1'b1;
  assign in_acc    = push && !full;
  assign empty     = !out_vld;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      raw_mode_r <= cfg_raw_mode;
    end
  end

  tee_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .raw_mode    (raw_mode_r),
    .accept      (in_acc),
    .text_byte   (in_text_byte),
    .end_of_text (in_end_of_text),
    .cmd         (cmd)
  );

  tee_cmd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .wr_data (cmd),
    .rd_en   (head_pop),
    .rd_data (head),
    .full    (full),
    .empty   (q_empty)
  );

  tee_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_vld (!q_empty),
    .head_pop (head_pop),
    .out_pop  (pop),
    .out_vld  (out_vld),
    .out_byte (out_byte),
    .out_last (out_last_of_run)
  );

endmodule

### design/tee_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Port checker
// Watches the top-level ports of the decoder over time.
// ----------------------------------------------------------------------------
module tee_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic       out_last_of_run,
  input logic       cfg_valid,
  input logic       cfg_ready
);

  // Reset leaves no result and room for input
  a_reset_clean: assert property (@(posedge clk) !rst_n |=> empty && !full)
    else $error("result or full flag present after reset");

  // A waiting result word holds until popped
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_byte) && $stable(out_last_of_run))
    else $error("waiting result changed or vanished");

  // The queue fills only through an accepted word
  a_full_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(full) |-> $past(push && !full))
    else $error("full rose without an accepted word");

  // Mode writes are never refused
  a_cfg_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("mode write refused");

endmodule

bind text_escape_entity_decoder tee_chk u_tee_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .push            (push),
  .full            (full),
  .empty           (empty),
  .pop             (pop),
  .out_byte        (out_byte),
  .out_last_of_run (out_last_of_run),
  .cfg_valid       (cfg_valid),
  .cfg_ready       (cfg_ready)
);
